FILE: hw/rtl/clfr_pkg.sv
// Shared types and constants for the character-LCD frame buffer refresh core.
package clfr_pkg;

    localparam int DEF_MAX_COLS = 20;
    localparam int DEF_MAX_ROWS = 4;

    localparam int OPCODE_W = 2;
    localparam int COLUMN_W = 6;
    localparam int ROW_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int COLS_W   = 5;
    localparam int ROWS_W   = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] HIGH_OFFSET  = 8'h80;
    localparam logic [CHAR_W-1:0] GLYPH_LIMIT  = 8'h08;
    localparam logic [CHAR_W-1:0] HIGH_LIMIT   = 8'h88;
    localparam logic [CHAR_W-1:0] DIRECT_ARG   = 8'h01;
    localparam logic [CHAR_W-1:0] ZERO_BYTE    = 8'h00;

    localparam logic [COLS_W-1:0] COLS_RESET   = 5'd20;
    localparam logic [ROWS_W-1:0] ROWS_RESET   = 3'd4;
    localparam logic [CHAR_W-1:0] CURSOR_RESET = 8'd17;
    localparam logic [CHAR_W-1:0] DIRECT_RESET = 8'd30;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FLUSH = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        REG_COLUMNS = 3'd0,
        REG_ROWS    = 3'd1,
        REG_MODE    = 3'd2,
        REG_CURSOR  = 3'd3,
        REG_DIRECT  = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_READ,
        ST_CELL,
        ST_ESC1,
        ST_CHAR
    } state_t;

    // Control bundle from the sequencer to the cell memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } mem_ctrl_t;

endpackage

FILE: hw/rtl/clfr_cmd_if.sv
// Command channel interface: one operation per transaction.
interface clfr_cmd_if
    import clfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [CHAR_W-1:0]   char_code;

    modport source (output valid, output opcode, output column, output row,
                    output char_code, input ready);
    modport sink   (input valid, input opcode, input column, input row,
                    input char_code, output ready);
endinterface

FILE: hw/rtl/clfr_disp_if.sv
// Display byte channel interface: one serial byte per transaction.
interface clfr_disp_if
    import clfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/clfr_cell_mem.sv
// Character cell memory with per-cell valid bits; invalid cells read as space.
module clfr_cell_mem
    import clfr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mem_ctrl_t         ctrl,
    input  logic [AW-1:0]     addr,
    input  logic [CHAR_W-1:0] wdata,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : SPACE_CODE;

endmodule

FILE: hw/rtl/char_lcd_framebuffer_refresh_core.sv
// Top level: frame buffer, row refresh sequencer and configuration registers.
// Commands: write and clear emit nothing; a flush moves to ST_HDR0, which
//   registers the first header byte once the output slot is free.
// Flow: one operation at a time; a flush sends three header bytes, then per
//   cell a read through the single read port of the cell memory and 1 or 3
//   bytes; any byte waits while the display stalls.
// Reset: asynchronous, active low; registers take their defaults and all cells
//   read as space at once, no clearing pass.
module char_lcd_framebuffer_refresh_core
    import clfr_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    clfr_cmd_if.sink           cmd,
    clfr_disp_if.source        disp
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [COLS_W-1:0] columns_used_reg;
    logic [ROWS_W-1:0] rows_used_reg;
    logic              new_firmware_mode_reg;
    logic [CHAR_W-1:0] cursor_command_code_reg;
    logic [CHAR_W-1:0] direct_send_code_reg;
    logic [2:0]        reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_used_reg        <= COLS_RESET;
            rows_used_reg           <= ROWS_RESET;
            new_firmware_mode_reg   <= 1'b0;
            cursor_command_code_reg <= CURSOR_RESET;
            direct_send_code_reg    <= DIRECT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_COLUMNS: columns_used_reg        <= pwdata[COLS_W-1:0];
                REG_ROWS:    rows_used_reg           <= pwdata[ROWS_W-1:0];
                REG_MODE:    new_firmware_mode_reg   <= pwdata[0];
                REG_CURSOR:  cursor_command_code_reg <= pwdata[CHAR_W-1:0];
                REG_DIRECT:  direct_send_code_reg    <= pwdata[CHAR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COLUMNS: prdata = PDATA_W'(columns_used_reg);
            REG_ROWS:    prdata = PDATA_W'(rows_used_reg);
            REG_MODE:    prdata = PDATA_W'(new_firmware_mode_reg);
            REG_CURSOR:  prdata = PDATA_W'(cursor_command_code_reg);
            REG_DIRECT:  prdata = PDATA_W'(direct_send_code_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Effective display size: clamp the size registers to 1..MAX
    // ---------------------------------------------------------------
    logic [COLS_W-1:0] eff_w;
    logic [ROW_W-1:0]  eff_h;

    always_comb
    begin
        if (columns_used_reg == '0)
            eff_w = COLS_W'(1);
        else if (columns_used_reg > COLS_W'(MAX_COLS))
            eff_w = COLS_W'(MAX_COLS);
        else
            eff_w = columns_used_reg;

        if (rows_used_reg == '0)
            eff_h = ROW_W'(1);
        else if (ROW_W'(rows_used_reg) > ROW_W'(MAX_ROWS))
            eff_h = ROW_W'(MAX_ROWS);
        else
            eff_h = ROW_W'(rows_used_reg);
    end

    // ---------------------------------------------------------------
    // Cell encoding for the serial link
    // ---------------------------------------------------------------
    // Returns {esc, data byte}; esc flags the direct-send prefix
    function automatic logic [CHAR_W:0] encode_cell(input logic [CHAR_W-1:0] c,
                                                    input logic mode);
        logic [CHAR_W-1:0] b;
        logic              esc;
        b   = c;
        esc = 1'b0;
        if (mode)
        begin
            if (c < GLYPH_LIMIT)
                b = c + HIGH_OFFSET;
            else if (c < SPACE_CODE || (c >= HIGH_OFFSET && c < HIGH_LIMIT))
                esc = 1'b1;
        end
        else if (c < SPACE_CODE)
        begin
            b = c + HIGH_OFFSET;
        end
        return {esc, b};
    endfunction

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [ROW_W-1:0]  rowm1_reg, rowm1_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    mem_ctrl_t         mem_ctrl;
    logic [AW-1:0]     mem_addr;
    logic [CHAR_W-1:0] mem_rdata;

    logic              slot_free;
    logic              cmd_acc;
    logic              wr_in_bounds;
    logic              row_ok;
    logic              last_cell;
    logic [CHAR_W:0]   enc;

    assign slot_free = !out_valid_reg || disp.ready;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign row_ok    = (cmd.row != '0) && (cmd.row <= eff_h);
    assign wr_in_bounds = (cmd.column != '0) && (cmd.column <= COLUMN_W'(eff_w)) && row_ok;
    assign last_cell = (COLS_W'(col_reg) == eff_w - COLS_W'(1));
    assign enc       = encode_cell(mem_rdata, new_firmware_mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        base_reg     <= base_next;
        rowm1_reg    <= rowm1_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        rowm1_next     = rowm1_reg;
        out_valid_next = out_valid_reg && !disp.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        mem_ctrl       = '0;
        mem_addr       = AW'(base_reg + AW'(col_reg));
        cmd.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd_acc)
                begin
                    case (cmd.opcode)
                        OP_WRITE:
                        begin
                            // Drop writes outside the effective display
                            mem_ctrl.wr_en = wr_in_bounds;
                            mem_addr = AW'(32'(cmd.row - ROW_W'(1)) * MAX_COLS
                                           + 32'(cmd.column - COLUMN_W'(1)));
                        end
                        OP_CLEAR:
                        begin
                            mem_ctrl.clear = 1'b1;
                        end
                        OP_FLUSH:
                        begin
                            if (row_ok)
                            begin
                                rowm1_next = cmd.row - ROW_W'(1);
                                base_next  = AW'(32'(cmd.row - ROW_W'(1)) * MAX_COLS);
                                col_next   = '0;
                                state_next = ST_HDR0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HDR0:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cursor_command_code_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_HDR1;
                end
            end
            ST_HDR1:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ZERO_BYTE;
                    out_last_next  = 1'b0;
                    state_next     = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CHAR_W'(rowm1_reg);
                    out_last_next  = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                // Fetch the current cell; data is ready next cycle and holds
                mem_ctrl.rd_en = 1'b1;
                state_next     = ST_CELL;
            end
            ST_CELL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (enc[CHAR_W])
                    begin
                        out_byte_next = direct_send_code_reg;
                        out_last_next = 1'b0;
                        state_next    = ST_ESC1;
                    end
                    else
                    begin
                        out_byte_next = enc[CHAR_W-1:0];
                        out_last_next = last_cell;
                        col_next      = col_reg + CW'(1);
                        state_next    = last_cell ? ST_IDLE : ST_READ;
                    end
                end
            end
            ST_ESC1:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = DIRECT_ARG;
                    out_last_next  = 1'b0;
                    state_next     = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = enc[CHAR_W-1:0];
                    out_last_next  = last_cell;
                    col_next       = col_reg + CW'(1);
                    state_next     = last_cell ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign disp.valid     = out_valid_reg;
    assign disp.out_byte  = out_byte_reg;
    assign disp.last_byte = out_last_reg;

    clfr_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (cmd.char_code),
        .rdata (mem_rdata)
    );

endmodule

FILE: hw/rtl/clfr_checker.sv
// Port-level checker for the refresh core, bound to the top level.
module clfr_checker
    import clfr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic [OPCODE_W-1:0] cmd_opcode,
    input logic                disp_valid,
    input logic                disp_ready,
    input logic [CHAR_W-1:0]   disp_byte,
    input logic                disp_last
);

    // A stalled display transaction holds its payload
    a_disp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && !disp_ready |=> disp_valid && $stable(disp_byte) && $stable(disp_last))
        else $error("display transaction changed while stalled");

    // Writes and clears never start a display byte
    a_no_byte_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode == OP_WRITE || cmd_opcode == OP_CLEAR)
        |=> !$rose(disp_valid))
        else $error("display byte after write or clear");

    // Mid-flush the core takes no new command
    a_busy_mid_flush: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_ready && !disp_last |-> !cmd_ready)
        else $error("command taken during a row flush");

    // A command accepted while the display is idle is not directly followed by a last byte
    a_flush_header_delay: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !disp_valid |=> !(disp_valid && disp_last))
        else $error("last byte directly after command acceptance");

endmodule

bind char_lcd_framebuffer_refresh_core clfr_checker u_clfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_opcode (cmd.opcode),
    .disp_valid (disp.valid),
    .disp_ready (disp.ready),
    .disp_byte  (disp.out_byte),
    .disp_last  (disp.last_byte)
);
